[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold at the same clock edge as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold at the clock edge after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bcm_pkg.sv]
// Types and constants shared by the cartridge mapper modules.
package bcm_pkg;

    // Item kinds on the command channel.
    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    // Bank select codes that map the external window onto RAM banks and clock registers.
    localparam logic [3:0] SEL_RAM_LAST = 4'h3;
    localparam logic [3:0] SEL_SECONDS  = 4'h8;
    localparam logic [3:0] SEL_MINUTES  = 4'h9;
    localparam logic [3:0] SEL_HOURS    = 4'hA;
    localparam logic [3:0] SEL_DAY_LOW  = 4'hB;
    localparam logic [3:0] SEL_DAY_HIGH = 4'hC;

    localparam logic [7:0] OPEN_BUS       = 8'hFF;
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] MAX_SECONDS    = 8'd59;
    localparam logic [7:0] MAX_MINUTES    = 8'd59;
    localparam logic [7:0] MAX_HOURS      = 8'd23;

    // Bit positions in the high day register.
    localparam int DAY_MSB_BIT = 0;
    localparam int HALT_BIT    = 6;

    localparam int ROM_OFFSET_W = 14;
    localparam int RAM_OFFSET_W = 13;
    localparam int ROM_ADDR_W   = 21;

    // Command from the decoder to the clock block.
    typedef struct packed {
        logic       tick;
        logic       wr_en;
        logic [3:0] sel;
        logic [7:0] wdata;
        logic [7:0] cycles;
    } rtc_cmd_t;

endpackage

[rtl/bcm_stream_if.sv]
// Valid/ready channel interfaces for mapper commands and responses.
interface bcm_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [7:0]  tick_cycles;

    modport source (output valid, mode, bus_address, write_data, tick_cycles, input ready);
    modport sink (input valid, mode, bus_address, write_data, tick_cycles, output ready);
endinterface

interface bcm_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        rom_fetch;
    logic [20:0] rom_address;

    modport source (output valid, read_data, rom_fetch, rom_address, input ready);
    modport sink (input valid, read_data, rom_fetch, rom_address, output ready);
endinterface

[rtl/bcm_ram.sv]
// Cartridge RAM: one write port and one registered read port.
module bcm_ram #(
    parameter int  DEPTH = 32768,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write and read are independent; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bcm_rtc.sv]
// Real-time clock: prescaler, subsecond counter and time-of-day cascade.
module bcm_rtc #(
    parameter int PRESCALE_DIVISOR    = 128,
    parameter int SUBTICKS_PER_SECOND = 32768
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bcm_pkg::rtc_cmd_t cmd,
    output logic [7:0]       rdata
);
    import bcm_pkg::*;

    localparam int PW = (PRESCALE_DIVISOR > 1) ? $clog2(PRESCALE_DIVISOR) : 1;
    localparam int SW = (SUBTICKS_PER_SECOND > 1) ? $clog2(SUBTICKS_PER_SECOND) : 1;
    localparam logic [8:0]  DIV9    = 9'(PRESCALE_DIVISOR);
    localparam logic [SW:0] SUB_LIM = (SW + 1)'(SUBTICKS_PER_SECOND);

    typedef logic [7:0] mod_tbl_t [256];

    // Tick cycle counts reduced by the prescale divisor, built at elaboration.
    function automatic mod_tbl_t build_cyc_mod();
        mod_tbl_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'(i % PRESCALE_DIVISOR);
        end
        return t;
    endfunction

    localparam mod_tbl_t CYC_MOD = build_cyc_mod();

    logic [PW-1:0] prescale_reg, prescale_next;
    logic [SW-1:0] sub_reg, sub_next;
    logic [7:0]    sec_reg, sec_next;
    logic [7:0]    min_reg, min_next;
    logic [7:0]    hr_reg, hr_next;
    logic [7:0]    day_lo_reg, day_lo_next;
    logic [7:0]    day_hi_reg, day_hi_next;

    logic [8:0]  pre_sum;
    logic [8:0]  pre_red;
    logic [8:0]  pre_rem;
    logic        sub_hit;
    logic [SW:0] sub_inc;
    logic        sec_hit;

    logic [7:0] sec_inc, min_cy, hr_cy;
    logic [7:0] sec_adv, min_adv, hr_adv, day_lo_adv, day_hi_adv;
    logic       day_roll;

    // Prescaler: the previous count stays below the divisor, so adding the
    // reduced cycle count needs only one compare and subtract.
    always_comb
    begin
        pre_sum = 9'(prescale_reg) + 9'(cmd.cycles);
        pre_red = 9'(prescale_reg) + 9'(CYC_MOD[cmd.cycles]);
        pre_rem = (pre_red >= DIV9) ? (pre_red - DIV9) : pre_red;
        sub_hit = (pre_sum >= DIV9);
        sub_inc = (SW + 1)'(sub_reg) + (SW + 1)'(1);
        sec_hit = (sub_inc >= SUB_LIM);
    end

    // One second of the time-of-day cascade; out-of-range values wrap.
    always_comb
    begin
        sec_inc = sec_reg + 8'd1;
        if (sec_inc > MAX_SECONDS)
        begin
            sec_adv = 8'd0;
            min_cy  = min_reg + 8'd1;
        end
        else
        begin
            sec_adv = sec_inc;
            min_cy  = min_reg;
        end
        if (min_cy > MAX_MINUTES)
        begin
            min_adv = 8'd0;
            hr_cy   = hr_reg + 8'd1;
        end
        else
        begin
            min_adv = min_cy;
            hr_cy   = hr_reg;
        end
        if (hr_cy > MAX_HOURS)
        begin
            hr_adv   = 8'd0;
            day_roll = 1'b1;
        end
        else
        begin
            hr_adv   = hr_cy;
            day_roll = 1'b0;
        end
        day_lo_adv = day_lo_reg;
        day_hi_adv = day_hi_reg;
        if (day_roll)
        begin
            if (day_lo_reg == 8'hFF)
            begin
                day_lo_adv = 8'd0;
                if (day_hi_reg[DAY_MSB_BIT])
                begin
                    // Day 511 rolls to 0 and sets the sticky carry.
                    day_hi_adv = {1'b1, day_hi_reg[6:1], 1'b0};
                end
                else
                begin
                    day_hi_adv = {day_hi_reg[7:1], 1'b1};
                end
            end
            else
            begin
                day_lo_adv = day_lo_reg + 8'd1;
            end
        end
    end

    // Next state: register writes, or a tick unless the clock is halted.
    always_comb
    begin
        prescale_next = prescale_reg;
        sub_next      = sub_reg;
        sec_next      = sec_reg;
        min_next      = min_reg;
        hr_next       = hr_reg;
        day_lo_next   = day_lo_reg;
        day_hi_next   = day_hi_reg;
        if (cmd.wr_en)
        begin
            case (cmd.sel)
                SEL_SECONDS:  sec_next    = cmd.wdata;
                SEL_MINUTES:  min_next    = cmd.wdata;
                SEL_HOURS:    hr_next     = cmd.wdata;
                SEL_DAY_LOW:  day_lo_next = cmd.wdata;
                SEL_DAY_HIGH: day_hi_next = cmd.wdata;
                default:      ;
            endcase
        end
        else if (cmd.tick && !day_hi_reg[HALT_BIT])
        begin
            if (sub_hit)
            begin
                prescale_next = PW'(pre_rem);
                sub_next      = sec_hit ? '0 : SW'(sub_inc);
                if (sec_hit)
                begin
                    sec_next    = sec_adv;
                    min_next    = min_adv;
                    hr_next     = hr_adv;
                    day_lo_next = day_lo_adv;
                    day_hi_next = day_hi_adv;
                end
            end
            else
            begin
                prescale_next = PW'(pre_sum);
            end
        end
    end

    // Clock state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            sub_reg      <= '0;
            sec_reg      <= '0;
            min_reg      <= '0;
            hr_reg       <= '0;
            day_lo_reg   <= '0;
            day_hi_reg   <= '0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            sub_reg      <= sub_next;
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            hr_reg       <= hr_next;
            day_lo_reg   <= day_lo_next;
            day_hi_reg   <= day_hi_next;
        end
    end

    // Register read for the current select.
    always_comb
    begin
        case (cmd.sel)
            SEL_SECONDS:  rdata = sec_reg;
            SEL_MINUTES:  rdata = min_reg;
            SEL_HOURS:    rdata = hr_reg;
            SEL_DAY_LOW:  rdata = day_lo_reg;
            SEL_DAY_HIGH: rdata = day_hi_reg;
            default:      rdata = OPEN_BUS;
        endcase
    end

endmodule

[rtl/banked_cartridge_mapper_with_rtc.sv]
// Top level of the banked cartridge mapper with real-time clock.
//
//   Channel | Dir | Payload                                        | Handshake
//   cmd     | in  | mode, bus_address, write_data, tick_cycles     | valid/ready
//   rsp     | out | read_data, rom_fetch, rom_address              | valid/ready
//
// One item is accepted per cycle while the output register is free or being
// emptied; its result is in the output register in the cycle after. A cartridge
// RAM read comes from the registered read port of the RAM, loaded at acceptance.
// Reset clears the bank selects, the RAM enable and all clock counters; the
// cartridge RAM has no clearing pass and holds undefined data until written.
// While a result is stalled it holds, and a new item is taken only in a
// cycle where the output register is empty or being emptied.
module banked_cartridge_mapper_with_rtc #(
    parameter int PRESCALE_DIVISOR    = 128,
    parameter int SUBTICKS_PER_SECOND = 32768,
    parameter int RAM_BANKS           = 4
) (
    input logic        clk,
    input logic        rst_n,
    bcm_cmd_if.sink    cmd,
    bcm_rsp_if.source  rsp
);
    import bcm_pkg::*;

    localparam int RAM_DEPTH = RAM_BANKS * (2 ** RAM_OFFSET_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    logic       ram_en_reg, ram_en_next;
    logic [6:0] rom_bank_reg, rom_bank_next;
    logic [3:0] ram_sel_reg, ram_sel_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [7:0]            rd_reg, rd_next;
    logic                  fetch_reg, fetch_next;
    logic [ROM_ADDR_W-1:0] raddr_reg, raddr_next;
    logic                  from_ram_reg, from_ram_next;

    logic        fire;
    logic        in_window;
    logic        sel_ram;
    logic        ram_ok;
    logic [6:0]  rom_bank_eff;
    logic [14:0] ram_index;
    logic        ram_we;
    logic        ram_re;
    logic [7:0]  ram_rdata;
    logic [7:0]  rtc_rdata;
    rtc_cmd_t    rtc_cmd;

    assign fire      = cmd.valid && cmd.ready;
    assign cmd.ready = !rsp_valid_reg || rsp.ready;

    // Address and select decode.
    assign in_window    = cmd.bus_address inside {[16'hA000:16'hBFFF]};
    assign sel_ram      = (ram_sel_reg <= SEL_RAM_LAST);
    assign ram_ok       = ram_en_reg && (ram_sel_reg < 4'(RAM_BANKS));
    assign rom_bank_eff = (rom_bank_reg == 7'd0) ? 7'd1 : rom_bank_reg;
    assign ram_index    = {ram_sel_reg[1:0], cmd.bus_address[RAM_OFFSET_W-1:0]};

    // Result of the current item.
    always_comb
    begin
        rd_next       = 8'd0;
        fetch_next    = 1'b0;
        raddr_next    = '0;
        from_ram_next = 1'b0;
        if (cmd.mode == MODE_READ)
        begin
            if (cmd.bus_address inside {[16'h0000:16'h3FFF]})
            begin
                fetch_next = 1'b1;
                raddr_next = ROM_ADDR_W'(cmd.bus_address);
            end
            else if (cmd.bus_address inside {[16'h4000:16'h7FFF]})
            begin
                fetch_next = 1'b1;
                raddr_next = {rom_bank_eff, cmd.bus_address[ROM_OFFSET_W-1:0]};
            end
            else if (in_window)
            begin
                if (!sel_ram)
                begin
                    rd_next = rtc_rdata;
                end
                else if (ram_ok)
                begin
                    from_ram_next = 1'b1;
                end
                else
                begin
                    rd_next = OPEN_BUS;
                end
            end
            else
            begin
                rd_next = OPEN_BUS;
            end
        end
    end

    // Mapper register updates and strobes to the RAM and the clock.
    always_comb
    begin
        ram_en_next   = ram_en_reg;
        rom_bank_next = rom_bank_reg;
        ram_sel_next  = ram_sel_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        rtc_cmd.tick  = 1'b0;
        rtc_cmd.wr_en = 1'b0;
        rtc_cmd.sel   = ram_sel_reg;
        rtc_cmd.wdata = cmd.write_data;
        rtc_cmd.cycles = cmd.tick_cycles;
        if (fire)
        begin
            case (cmd.mode)
                MODE_READ:
                begin
                    ram_re = in_window && sel_ram && ram_ok;
                end
                MODE_WRITE:
                begin
                    if (cmd.bus_address inside {[16'h0000:16'h1FFF]})
                    begin
                        ram_en_next = (cmd.write_data[3:0] == RAM_ENABLE_KEY);
                    end
                    else if (cmd.bus_address inside {[16'h2000:16'h3FFF]})
                    begin
                        rom_bank_next = cmd.write_data[6:0];
                    end
                    else if (cmd.bus_address inside {[16'h4000:16'h5FFF]})
                    begin
                        ram_sel_next = cmd.write_data[3:0];
                    end
                    else if (in_window)
                    begin
                        ram_we        = sel_ram && ram_ok;
                        rtc_cmd.wr_en = !sel_ram;
                    end
                end
                MODE_TICK:
                begin
                    rtc_cmd.tick = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Output register occupancy.
    always_comb
    begin
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_en_reg    <= 1'b0;
            rom_bank_reg  <= '0;
            ram_sel_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            ram_en_reg    <= ram_en_next;
            rom_bank_reg  <= rom_bank_next;
            ram_sel_reg   <= ram_sel_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload, loaded when an item is accepted.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_reg       <= rd_next;
            fetch_reg    <= fetch_next;
            raddr_reg    <= raddr_next;
            from_ram_reg <= from_ram_next;
        end
    end

    bcm_ram #(
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_index[RAM_AW-1:0]),
        .wdata (cmd.write_data),
        .re    (ram_re),
        .raddr (ram_index[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    bcm_rtc #(
        .PRESCALE_DIVISOR    (PRESCALE_DIVISOR),
        .SUBTICKS_PER_SECOND (SUBTICKS_PER_SECOND)
    ) u_rtc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rtc_cmd),
        .rdata (rtc_rdata)
    );

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = from_ram_reg ? ram_rdata : rd_reg;
    assign rsp.rom_fetch   = fetch_reg;
    assign rsp.rom_address = raddr_reg;

endmodule

[rtl/bcm_checker.sv]
// Port-level checker for the mapper and its bind to the top level.
`include "assert_macros.svh"

module bcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  cmd_mode,
    input logic [15:0] cmd_addr,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [7:0]  rsp_read_data,
    input logic        rsp_rom_fetch,
    input logic [20:0] rsp_rom_address
);
    import bcm_pkg::*;

    logic cmd_fire;
    logic non_read;
    logic fixed_read;

    assign cmd_fire   = cmd_valid && cmd_ready;
    assign non_read   = cmd_fire && (cmd_mode != MODE_READ);
    assign fixed_read = cmd_fire && (cmd_mode == MODE_READ) && (cmd_addr[15:14] == 2'b00);

    // A pending result is not dropped before it is taken.
    `ASSERT_NEXT_CYCLE(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // Every accepted item yields a result in the following cycle.
    `ASSERT_NEXT_CYCLE(a_item_result, clk, rst_n, cmd_fire, rsp_valid, "accepted item produced no response")

    // With the output register empty, the block takes a command.
    `ASSERT_SAME_CYCLE(a_ready_empty, clk, rst_n, cmd_valid && !rsp_valid, cmd_ready, "command refused while output empty")

    // Writes, ticks and unused codes give an all-zero result.
    `ASSERT_NEXT_CYCLE(a_zero_result, clk, rst_n, non_read, (rsp_read_data == 8'h00) && !rsp_rom_fetch && (rsp_rom_address == 21'h0), "non-read item gave a nonzero result")

    // The fixed bank maps straight to the bus address.
    `ASSERT_NEXT_CYCLE(a_fixed_bank, clk, rst_n, fixed_read, rsp_rom_fetch && (rsp_rom_address == 21'($past(cmd_addr))), "fixed bank read mapped wrongly")

endmodule

bind banked_cartridge_mapper_with_rtc bcm_checker u_bcm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_mode        (cmd.mode),
    .cmd_addr        (cmd.bus_address),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_data   (rsp.read_data),
    .rsp_rom_fetch   (rsp.rom_fetch),
    .rsp_rom_address (rsp.rom_address)
);

[tb/tb_banked_cartridge_mapper_with_rtc.sv]
// Self-checking testbench for the banked cartridge mapper with real-time clock.
`timescale 1ns / 100ps

module tb_banked_cartridge_mapper_with_rtc;
    import bcm_pkg::*;

    // Mode code that the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // CPU address map of the cartridge.
    localparam logic [15:0] ROM_FIXED_END  = 16'h3FFF;
    localparam logic [15:0] ROM_BANKED_END = 16'h7FFF;
    localparam logic [15:0] ENABLE_END     = 16'h1FFF;
    localparam logic [15:0] ROM_BANK_END   = 16'h3FFF;
    localparam logic [15:0] SELECT_END     = 16'h5FFF;
    localparam logic [15:0] WINDOW_LO      = 16'hA000;
    localparam logic [15:0] WINDOW_HI      = 16'hBFFF;

    localparam int PRESCALE_DIVISOR    = 128;
    localparam int SUBTICKS_PER_SECOND = 32768;
    localparam int DAY_CARRY_BIT       = 7;

    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_PRINTED    = 40;
    localparam int CLOCK_TICKS    = 12;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_fetch;
        logic [20:0] rom_address;
    } mapper_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bcm_cmd_if cmd_ch ();
    bcm_rsp_if rsp_ch ();

    banked_cartridge_mapper_with_rtc i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // Shadow copy of the mapper state.
    logic        shadow_ram_en;
    logic [6:0]  shadow_rom_bank;
    logic [3:0]  shadow_ram_sel;
    logic [7:0]  shadow_cart_ram [32768];
    bit          ram_written [32768];
    logic [14:0] written_list [$];
    logic [8:0]  prescale_count;
    logic [14:0] subsecond_count;
    logic [7:0]  rtc_seconds;
    logic [7:0]  rtc_minutes;
    logic [7:0]  rtc_hours;
    logic [7:0]  rtc_day_low;
    logic [7:0]  rtc_day_high;

    mapper_result_t expected_results [$];

    int mismatch_count   = 0;
    int items_sent       = 0;
    int results_checked  = 0;
    int sender_idle_pct  = 0;
    int receiver_idle_pct = 0;
    bit stall_request    = 1'b0;
    int stall_left       = 0;
    int quiet_cycles     = 0;

    function automatic logic in_window(logic [15:0] addr);
        return addr >= WINDOW_LO && addr <= WINDOW_HI;
    endfunction

    function automatic logic [14:0] ram_index(logic [15:0] addr);
        return {shadow_ram_sel[1:0], addr[12:0]};
    endfunction

    // Works out the result of one item and moves the shadow state on.
    function automatic mapper_result_t predict_mapper_result(logic [1:0] mode, logic [15:0] addr,
                                                             logic [7:0] data, logic [7:0] cycles);
        mapper_result_t res;
        logic [14:0] idx;
        int prescale_sum;
        int subsecond_next;
        res = '0;
        idx = ram_index(addr);
        case (mode)
            MODE_READ: begin
                if (addr <= ROM_FIXED_END) begin
                    res.rom_fetch = 1'b1;
                    res.rom_address = {5'd0, addr};
                end else if (addr <= ROM_BANKED_END) begin
                    res.rom_fetch = 1'b1;
                    res.rom_address = {(shadow_rom_bank == 7'd0) ? 7'd1 : shadow_rom_bank,
                                       addr[ROM_OFFSET_W-1:0]};
                end else if (in_window(addr)) begin
                    if (shadow_ram_sel <= SEL_RAM_LAST) begin
                        res.read_data = shadow_ram_en ? shadow_cart_ram[idx] : OPEN_BUS;
                    end else begin
                        case (shadow_ram_sel)
                            SEL_SECONDS:  res.read_data = rtc_seconds;
                            SEL_MINUTES:  res.read_data = rtc_minutes;
                            SEL_HOURS:    res.read_data = rtc_hours;
                            SEL_DAY_LOW:  res.read_data = rtc_day_low;
                            SEL_DAY_HIGH: res.read_data = rtc_day_high;
                            default:      res.read_data = OPEN_BUS;
                        endcase
                    end
                end else begin
                    res.read_data = OPEN_BUS;
                end
            end
            MODE_WRITE: begin
                if (addr <= ENABLE_END) begin
                    shadow_ram_en = (data[3:0] == RAM_ENABLE_KEY);
                end else if (addr <= ROM_BANK_END) begin
                    shadow_rom_bank = data[6:0];
                end else if (addr <= SELECT_END) begin
                    shadow_ram_sel = data[3:0];
                end else if (in_window(addr)) begin
                    if (shadow_ram_sel <= SEL_RAM_LAST) begin
                        if (shadow_ram_en) begin
                            shadow_cart_ram[idx] = data;
                            if (!ram_written[idx]) begin
                                ram_written[idx] = 1'b1;
                                written_list.push_back(idx);
                            end
                        end
                    end else begin
                        case (shadow_ram_sel)
                            SEL_SECONDS:  rtc_seconds = data;
                            SEL_MINUTES:  rtc_minutes = data;
                            SEL_HOURS:    rtc_hours = data;
                            SEL_DAY_LOW:  rtc_day_low = data;
                            SEL_DAY_HIGH: rtc_day_high = data;
                            default: ;
                        endcase
                    end
                end
            end
            MODE_TICK: begin
                // Prescaler, then subticks, then the seconds cascade.
                if (!rtc_day_high[HALT_BIT]) begin
                    prescale_sum = (int'(prescale_count) + int'(cycles)) & 'h1FF;
                    if (prescale_sum >= PRESCALE_DIVISOR) begin
                        prescale_count = 9'(prescale_sum % PRESCALE_DIVISOR);
                        subsecond_next = int'(subsecond_count) + 1;
                        if (subsecond_next >= SUBTICKS_PER_SECOND) begin
                            subsecond_next = subsecond_next % SUBTICKS_PER_SECOND;
                            rtc_seconds = rtc_seconds + 8'd1;
                            if (rtc_seconds > MAX_SECONDS) begin
                                rtc_seconds = 8'd0;
                                rtc_minutes = rtc_minutes + 8'd1;
                            end
                            if (rtc_minutes > MAX_MINUTES) begin
                                rtc_minutes = 8'd0;
                                rtc_hours = rtc_hours + 8'd1;
                            end
                            if (rtc_hours > MAX_HOURS) begin
                                rtc_hours = 8'd0;
                                if (rtc_day_low == 8'hFF) begin
                                    rtc_day_low = 8'd0;
                                    if (rtc_day_high[DAY_MSB_BIT]) begin
                                        rtc_day_high[DAY_MSB_BIT] = 1'b0;
                                        rtc_day_high[DAY_CARRY_BIT] = 1'b1;
                                    end else begin
                                        rtc_day_high[DAY_MSB_BIT] = 1'b1;
                                    end
                                end else begin
                                    rtc_day_low = rtc_day_low + 8'd1;
                                end
                            end
                        end
                        subsecond_count = 15'(subsecond_next);
                    end else begin
                        prescale_count = 9'(prescale_sum);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Picks a window address whose RAM byte in the current bank holds data, else a random one.
    function automatic logic [15:0] pick_written_address();
        logic [15:0] addr;
        logic [14:0] idx;
        int k;
        addr = WINDOW_LO + 16'($urandom_range(0, 16'h1FFF));
        if (written_list.size() != 0) begin
            for (k = 0; k < 16; k++) begin
                idx = written_list[$urandom_range(0, written_list.size() - 1)];
                if (idx[14:13] == shadow_ram_sel[1:0]) begin
                    addr = {3'b101, idx[12:0]};
                    break;
                end
            end
        end
        return addr;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $time, field, got, want);
    endtask

    // Offers one item, waits for it to be taken and records its expected result.
    task automatic send_item(input logic [1:0] mode, input logic [15:0] addr,
                             input logic [7:0] data, input logic [7:0] cycles);
        logic [1:0] m;
        m = mode;
        // A read of an enabled RAM byte never written is turned into a write of it.
        if (m == MODE_READ && in_window(addr) && shadow_ram_en
            && shadow_ram_sel <= SEL_RAM_LAST && !ram_written[ram_index(addr)])
            m = MODE_WRITE;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= m;
        cmd_ch.bus_address <= addr;
        cmd_ch.write_data  <= data;
        cmd_ch.tick_cycles <= cycles;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        expected_results.push_back(predict_mapper_result(m, addr, data, cycles));
        items_sent++;
    endtask

    task automatic write_bus(input logic [15:0] addr, input logic [7:0] data);
        send_item(MODE_WRITE, addr, data, 8'($urandom_range(0, 255)));
    endtask

    task automatic read_bus(input logic [15:0] addr);
        send_item(MODE_READ, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_tick(input logic [7:0] cycles);
        send_item(MODE_TICK, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                  cycles);
    endtask

    task automatic select_bank(input logic [3:0] sel);
        write_bus(16'h4000 + 16'($urandom_range(0, 16'h1FFF)),
                  {4'($urandom_range(0, 15)), sel});
    endtask

    function automatic logic [15:0] window_address();
        return WINDOW_LO + 16'($urandom_range(0, 16'h1FFF));
    endfunction

    // Stops offering items until every expected result has come back.
    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // Field extremes, every mode and the special cases of the address map.
    task automatic test_directed_cases();
        read_bus(16'h0000);
        read_bus(ROM_FIXED_END);
        read_bus(16'h4000);                 // bank zero maps as bank one
        read_bus(WINDOW_LO);                // RAM still disabled
        write_bus(16'h0000, 8'h0A);
        write_bus(WINDOW_LO, 8'h00);
        select_bank(SEL_RAM_LAST);
        write_bus(WINDOW_HI, 8'hFF);
        read_bus(WINDOW_HI);
        write_bus(16'h4000, 8'h00);
        read_bus(WINDOW_LO);
        write_bus(ENABLE_END, 8'hF5);       // disables RAM
        write_bus(WINDOW_LO, 8'h77);        // ignored while disabled
        read_bus(WINDOW_LO);
        write_bus(16'h2000, 8'hFF);
        read_bus(ROM_BANKED_END);
        write_bus(ROM_BANK_END, 8'h80);     // bank field reads as zero
        read_bus(16'h5555);
        write_bus(16'h4000, 8'h07);         // select with no RAM bank behind it
        read_bus(16'hA123);
        // Halted clock ignores ticks; the halt register is reachable without RAM enable.
        select_bank(SEL_DAY_HIGH);
        write_bus(WINDOW_LO, 8'h40);
        send_tick(8'hFF);
        read_bus(WINDOW_LO);
        write_bus(WINDOW_LO, 8'h00);
        send_tick(8'h00);
        send_tick(8'hFF);
        // Unmapped ranges and the latch range.
        write_bus(16'h6000, 8'h01);
        write_bus(16'hC000, 8'hAA);
        read_bus(16'h8000);
        read_bus(16'hFFFF);
        send_item(MODE_UNUSED, 16'hA000, 8'hFF, 8'hFF);
        // Re-enable: the write made while disabled must not have landed.
        write_bus(16'h0000, 8'h1A);
        select_bank(4'h0);
        read_bus(WINDOW_LO);
    endtask

    // Random traffic built mostly from well-formed access sequences.
    task automatic test_random_traffic(input int count);
        int stop_at;
        int k;
        int n;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    write_bus(16'($urandom_range(0, ENABLE_END)),
                              {4'($urandom_range(0, 15)),
                               ($urandom_range(0, 4) != 0) ? RAM_ENABLE_KEY
                                                           : 4'($urandom_range(0, 15))});
                    select_bank(4'($urandom_range(0, 3)));
                    n = $urandom_range(2, 6);
                    for (k = 0; k < n; k++)
                        write_bus(window_address(), 8'($urandom_range(0, 255)));
                    n = $urandom_range(2, 6);
                    for (k = 0; k < n; k++) read_bus(pick_written_address());
                end
                2: begin
                    select_bank(SEL_SECONDS + 4'($urandom_range(0, 4)));
                    if ($urandom_range(0, 1) != 0)
                        write_bus(window_address(), 8'($urandom_range(0, 255)));
                    read_bus(window_address());
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++) send_tick(8'($urandom_range(0, 255)));
                    read_bus(window_address());
                end
                3, 4: begin
                    write_bus(16'h2000 + 16'($urandom_range(0, 16'h1FFF)),
                              8'($urandom_range(0, 255)));
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++) read_bus(16'($urandom_range(0, ROM_BANKED_END)));
                end
                5, 6: begin
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++) send_tick(8'($urandom_range(0, 255)));
                end
                7: begin
                    if ($urandom_range(0, 1) != 0)
                        send_item(2'($urandom_range(0, 1)),
                                  16'($urandom_range(16'h6000, 16'h9FFF)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    else
                        send_item(2'($urandom_range(0, 1)),
                                  16'($urandom_range(16'hC000, 16'hFFFF)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                default: begin
                    send_item(($urandom_range(0, 31) == 0) ? MODE_UNUSED
                                                           : 2'($urandom_range(0, 2)),
                              16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // The receiver holds off while items keep coming, then the sender waits it out.
    task automatic test_output_backpressure();
        int saved_pct;
        int k;
        saved_pct = sender_idle_pct;
        sender_idle_pct = 0;
        stall_request = 1'b1;
        for (k = 0; k < 24; k++) begin
            if (k % 3 == 0) send_tick(8'($urandom_range(0, 255)));
            else read_bus(16'($urandom_range(0, ROM_BANKED_END)));
        end
        sender_idle_pct = saved_pct;
        wait_for_results();
    endtask

    // Loads the clock registers, ticks for a while and reads them back. A full
    // second takes tens of thousands of ticks, so only the prescaler and the
    // subtick counter move here.
    task automatic test_clock_registers(input logic [7:0] sec, input logic [7:0] minute,
                                        input logic [7:0] hour, input logic [7:0] day_lo,
                                        input logic [7:0] day_hi);
        int k;
        logic [3:0] sel;
        select_bank(SEL_SECONDS);
        write_bus(window_address(), sec);
        select_bank(SEL_MINUTES);
        write_bus(window_address(), minute);
        select_bank(SEL_HOURS);
        write_bus(window_address(), hour);
        select_bank(SEL_DAY_LOW);
        write_bus(window_address(), day_lo);
        select_bank(SEL_DAY_HIGH);
        write_bus(window_address(), day_hi & ~(8'h01 << HALT_BIT));
        for (k = 0; k < CLOCK_TICKS; k++) begin
            if ($urandom_range(0, 15) == 0) send_tick(8'($urandom_range(0, 255)));
            else send_tick(8'($urandom_range(PRESCALE_DIVISOR, 255)));
        end
        for (sel = SEL_SECONDS; sel <= SEL_DAY_HIGH; sel++) begin
            select_bank(sel);
            read_bus(window_address());
        end
    endtask

    // Receiver side: random ready, with a long hold-off on request.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (stall_request) begin
            stall_request = 1'b0;
            stall_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Compare every accepted result with the oldest expected one.
    always @(posedge clk) begin
        mapper_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, read_data", 32'(rsp_ch.read_data), 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (rsp_ch.read_data !== want.read_data)
                    report_mismatch("read_data", 32'(rsp_ch.read_data), 32'(want.read_data));
                if (rsp_ch.rom_fetch !== want.rom_fetch)
                    report_mismatch("rom_fetch", 32'(rsp_ch.rom_fetch), 32'(want.rom_fetch));
                if (rsp_ch.rom_address !== want.rom_address)
                    report_mismatch("rom_address", 32'(rsp_ch.rom_address),
                                    32'(want.rom_address));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d cycles without progress", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        cmd_ch.valid       = 1'b0;
        cmd_ch.mode        = MODE_READ;
        cmd_ch.bus_address = 16'h0000;
        cmd_ch.write_data  = 8'h00;
        cmd_ch.tick_cycles = 8'h00;
        rsp_ch.ready       = 1'b0;
        shadow_ram_en   = 1'b0;
        shadow_rom_bank = 7'd0;
        shadow_ram_sel  = 4'd0;
        prescale_count  = 9'd0;
        subsecond_count = 15'd0;
        rtc_seconds     = 8'd0;
        rtc_minutes     = 8'd0;
        rtc_hours       = 8'd0;
        rtc_day_low     = 8'd0;
        rtc_day_high    = 8'd0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles less often than the receiver.
        sender_idle_pct = 27;
        receiver_idle_pct = 53;
        test_directed_cases();
        test_random_traffic(480);
        test_output_backpressure();
        test_clock_registers(MAX_SECONDS, MAX_MINUTES, MAX_HOURS, 8'hFF, 8'h81);

        // Receiver idles less often than the sender.
        sender_idle_pct = 53;
        receiver_idle_pct = 27;
        test_random_traffic(480);
        test_clock_registers(MAX_SECONDS, MAX_MINUTES, MAX_HOURS, 8'hFF, 8'h00);

        // Full rate on both sides.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random_traffic(480);
        test_output_backpressure();
        test_clock_registers(8'hC7, 8'hEE, 8'h80, 8'h41, 8'h3E);

        wait_for_results();
        repeat (4) @(posedge clk);

        $display("Run covered %0d items and %0d results, with clock register loads and ticks",
                 items_sent, results_checked);
        $display("Traffic mixed ROM, RAM, clock and unmapped accesses under three idling mixes");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
